// ===== rtl/core/rbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_pkg: ring buffer deque shared definitions
// Request/response payloads, operation and status codes, and the
// controller-to-datapath command and status bundles.
// ----------------------------------------------------------------------------
package rbd_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_LOAD
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] push_value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               read_valid;
    logic [1:0]         status;
    logic [10:0]        count;
    logic               empty_res;
  } out_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic execute;
    logic load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/ring_buffer_deque.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ring_buffer_deque: double-ended queue in a circular store
// Push/pop/peek at either end of a DEPTH-entry store, one response per
// request carrying the read value, status, and resulting element count.
// ----------------------------------------------------------------------------
// Each request passes through a capture step, the single memory access
// (write for a push, read for a pop or peek) together with the pointer and
// count update, and a load step that brings the registered read data into
// the output register. The output register is separate from the sequencer,
// so a new request is accepted while the previous response is still
// waiting on out_ready_i; the load step stretches only while that earlier
// response is unclaimed.
// The front grows upward from front pointer, the back grows downward from
// back pointer, both wrapping at DEPTH. A push on a full queue is refused
// with status 2; a pop or peek on an empty queue returns read_valid 0 and
// status 1. count reports the low 11 bits of the element count. Entries are
// never cleared; only written entries are ever read back, so no clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module ring_buffer_deque #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rbd_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rbd_pkg::out_rsp_t      out_rsp_o
);
  import rbd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: idle -> access -> load
  rbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // store, pointers, count and response register
  rbd_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // a request occupies the sequencer for at least its access and load cycles
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("request accepted before previous one finished");

  // a found element always comes with an ok status
  a_valid_implies_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.read_valid |-> out_rsp_o.status == STAT_OK)
    else $error("read_valid with non-ok status");

  // a refused push means the queue held elements
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == STAT_FULL |-> !out_rsp_o.empty_res)
    else $error("full status reported on empty queue");

  // an empty miss never carries data
  a_empty_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == STAT_EMPTY
      |-> !out_rsp_o.read_valid && out_rsp_o.empty_res && out_rsp_o.read_value == 32'sd0)
    else $error("empty status with data");

endmodule
`default_nettype wire

// ===== rtl/core/rbd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_ctrl: ring buffer deque sequencer
// Steps each request through capture, memory access and result load.
// ----------------------------------------------------------------------------
module rbd_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire rbd_pkg::dp_sts_t sts_i,
  output rbd_pkg::dp_cmd_t     cmd_o
);
  import rbd_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_ACCESS;
      end
      S_ACCESS: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (!sts_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_ACCESS: begin
        cmd_o.execute = 1'b1;
      end
      S_LOAD: begin
        cmd_o.load = !sts_i.out_busy;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/rbd_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_dpath: ring buffer deque datapath
// Entry memory, front/back pointers, element count and output register.
// ----------------------------------------------------------------------------
module rbd_dpath #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rbd_pkg::in_req_t  in_req_i,
  input  wire rbd_pkg::dp_cmd_t  cmd_i,
  output rbd_pkg::dp_sts_t       sts_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output rbd_pkg::out_rsp_t      out_rsp_o
);
  import rbd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // captured request
  op_e         op_q;
  logic [31:0] val_q;

  // queue state
  logic [PW-1:0] front_q, front_d, back_q, back_d;
  logic [CW-1:0] count_q, count_d;
  logic          rvalid_q, rvalid_d;
  status_e       stat_q, stat_d;

  // memory
  logic [31:0]   mem_q [DEPTH];
  logic [31:0]   rdata_q;
  logic          mem_we, mem_re;
  logic [PW-1:0] waddr, raddr;

  // output register
  logic          out_valid_q;
  out_rsp_t      out_q;

  logic [PW-1:0] front_dec, back_dec, back_inc, front_inc;
  logic          full, empty;
  logic [CW+10:0] count_ext;

  assign front_inc = (front_q == LAST) ? '0 : front_q + PW'(1);
  assign front_dec = (front_q == '0) ? LAST : front_q - PW'(1);
  assign back_inc  = (back_q == LAST) ? '0 : back_q + PW'(1);
  assign back_dec  = (back_q == '0) ? LAST : back_q - PW'(1);
  assign full      = (count_q == FULL_CNT);
  assign empty     = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(in_req_i.op);
      val_q <= in_req_i.push_value;
    end
  end

  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    count_d  = count_q;
    rvalid_d = rvalid_q;
    stat_d   = stat_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    waddr    = front_q;
    raddr    = front_q;
    if (cmd_i.execute) begin
      rvalid_d = 1'b0;
      stat_d   = STAT_OK;
      unique case (op_q)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (full) begin
            stat_d = STAT_FULL;
          end else begin
            mem_we  = 1'b1;
            count_d = count_q + CW'(1);
            if (op_q == OP_PUSH_FRONT) begin
              waddr   = front_q;
              front_d = front_inc;
            end else begin
              waddr  = back_dec;
              back_d = back_dec;
            end
          end
        end
        OP_POP_FRONT, OP_PEEK_FRONT: begin
          if (empty) begin
            stat_d = STAT_EMPTY;
          end else begin
            mem_re   = 1'b1;
            rvalid_d = 1'b1;
            raddr    = front_dec;
            if (op_q == OP_POP_FRONT) begin
              front_d = front_dec;
              count_d = count_q - CW'(1);
            end
          end
        end
        OP_POP_BACK, OP_PEEK_BACK: begin
          if (empty) begin
            stat_d = STAT_EMPTY;
          end else begin
            mem_re   = 1'b1;
            rvalid_d = 1'b1;
            raddr    = back_q;
            if (op_q == OP_POP_BACK) begin
              back_d  = back_inc;
              count_d = count_q - CW'(1);
            end
          end
        end
        default: ;  // undefined codes: status ok, no read, pointers and count unchanged
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      back_q   <= '0;
      count_q  <= '0;
      rvalid_q <= 1'b0;
      stat_q   <= STAT_OK;
    end else begin
      front_q  <= front_d;
      back_q   <= back_d;
      count_q  <= count_d;
      rvalid_q <= rvalid_d;
      stat_q   <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= val_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= mem_q[raddr];
  end

  // result assembly
  assign count_ext = {11'd0, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.read_value <= rvalid_q ? rdata_q : 32'd0;
      out_q.read_valid <= rvalid_q;
      out_q.status     <= stat_q;
      out_q.count      <= count_ext[10:0];
      out_q.empty_res  <= empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_rsp_o      = out_q;

endmodule
`default_nettype wire
